// ----- rtl/csc_pkg.sv -----
// Shared types, constants and classification functions for the color sorter controller.
// Depends on nothing; csc_front, csc_back and the top level use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

	localparam int unsigned WidthW   = 14;
	localparam int unsigned DelayW   = 13;
	localparam int unsigned HoldCfgW = 10;
	localparam int unsigned HoldW    = 11;
	localparam int unsigned CountW   = 16;
	localparam int unsigned AddrW    = 4;
	localparam int unsigned DataW    = 32;

	localparam int unsigned MID_DEPTH_DEFAULT = 2;
	localparam int unsigned OUT_DEPTH_DEFAULT = 2;

	localparam logic [1:0] REG_RED_DELAY    = 2'd0;
	localparam logic [1:0] REG_YELLOW_DELAY = 2'd1;
	localparam logic [1:0] REG_SERVO_HOLD   = 2'd2;

	localparam logic [DelayW-1:0]   RED_DELAY_RESET    = 13'd1000;
	localparam logic [DelayW-1:0]   YELLOW_DELAY_RESET = 13'd4000;
	localparam logic [HoldCfgW-1:0] SERVO_HOLD_RESET   = 10'd400;

	localparam logic [WidthW-1:0] TIMEOUT_WIDTH = 14'd9999;
	localparam logic [DelayW-1:0] ELAPSED_MAX   = 13'd8191;
	localparam logic [HoldW-1:0]  HOLD_MAX      = 11'd2047;

	localparam logic [WidthW-1:0] RED_R_LO    = 14'd10;
	localparam logic [WidthW-1:0] RED_R_HI    = 14'd47;
	localparam logic [WidthW-1:0] RED_G_LO    = 14'd50;
	localparam logic [WidthW-1:0] RED_B_LO    = 14'd30;
	localparam logic [WidthW-1:0] BLUE_B_HI   = 14'd100;
	localparam logic [WidthW-1:0] BLUE_R_LO   = 14'd110;
	localparam logic [WidthW-1:0] BLUE_G_LO   = 14'd90;
	localparam logic [WidthW-1:0] YEL_R_MAX   = 14'd12;
	localparam logic [WidthW-1:0] YEL_G_HI    = 14'd55;
	localparam logic [WidthW-1:0] YEL_B_HI    = 14'd40;

	typedef enum logic [1:0] {
		COLOR_NONE   = 2'd0,
		COLOR_RED    = 2'd1,
		COLOR_BLUE   = 2'd2,
		COLOR_YELLOW = 2'd3
	} color_t;

	typedef struct packed {
		logic [DelayW-1:0]   red_delay;
		logic [DelayW-1:0]   yellow_delay;
		logic [HoldCfgW-1:0] servo_hold;
	} cfg_t;

	typedef struct packed {
		color_t sample_color;
		logic   sensor_one;
		logic   sensor_two;
		logic   sensor_three;
	} tick_t;

	typedef struct packed {
		logic              push_red;
		logic              push_yellow;
		logic              blue_passed;
		color_t            held_color;
		logic [CountW-1:0] red_total;
		logic [CountW-1:0] yellow_total;
		logic [CountW-1:0] blue_total;
		logic              busy;
	} result_t;

	function automatic logic [WidthW-1:0] fix_width(input logic [WidthW-1:0] w);
		return (w == '0) ? TIMEOUT_WIDTH : w;
	endfunction

	function automatic color_t classify(
		input logic [WidthW-1:0] r,
		input logic [WidthW-1:0] g,
		input logic [WidthW-1:0] b
	);
		color_t c;
		c = COLOR_NONE;
		if (r > RED_R_LO && r < RED_R_HI && g > RED_G_LO && b > RED_B_LO) begin
			c = COLOR_RED;
		end else if (b < BLUE_B_HI && r > BLUE_R_LO && g > BLUE_G_LO) begin
			c = COLOR_BLUE;
		end else if (r <= YEL_R_MAX && g < YEL_G_HI && b < YEL_B_HI) begin
			c = COLOR_YELLOW;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/csc_fifo.sv -----
// Small generic register queue with registered storage and occupancy count.
// Depends on nothing; used between front and back and at the result side.
`timescale 1ns / 1ps
`default_nettype none

module csc_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/csc_front.sv -----
// Front part: cleans up the pulse widths and classifies the color sample of a tick.
// Depends on csc_pkg for the thresholds and the tick record type.
`timescale 1ns / 1ps
`default_nettype none

module csc_front (
	input  wire logic                       color_valid,
	input  wire logic [csc_pkg::WidthW-1:0] red_width,
	input  wire logic [csc_pkg::WidthW-1:0] green_width,
	input  wire logic [csc_pkg::WidthW-1:0] blue_width,
	input  wire logic                       sensor_one_level,
	input  wire logic                       sensor_two_level,
	input  wire logic                       sensor_three_level,
	output csc_pkg::tick_t                  tick
);

	csc_pkg::color_t color;

	always_comb begin
		color = csc_pkg::classify(csc_pkg::fix_width(red_width),
			csc_pkg::fix_width(green_width), csc_pkg::fix_width(blue_width));
		tick.sample_color = color_valid ? color : csc_pkg::COLOR_NONE;
		tick.sensor_one   = sensor_one_level;
		tick.sensor_two   = sensor_two_level;
		tick.sensor_three = sensor_three_level;
	end

endmodule

`default_nettype wire

// ----- rtl/csc_back.sv -----
// Back part: lane timers, latched color, busy window and object counts, one tick per transfer.
// Depends on csc_pkg for the tick, result and configuration types.
`timescale 1ns / 1ps
`default_nettype none

module csc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire csc_pkg::cfg_t    cfg,
	input  wire csc_pkg::tick_t   tick,
	input  wire logic             tick_ready,
	input  wire logic             result_room,
	output logic                  fire,
	output csc_pkg::result_t      result
);

	localparam int unsigned SumW = csc_pkg::HoldW + 2;

	csc_pkg::color_t                  color_q;
	logic                             red_armed_q;
	logic                             yellow_armed_q;
	logic [csc_pkg::DelayW-1:0]       red_elapsed_q;
	logic [csc_pkg::DelayW-1:0]       yellow_elapsed_q;
	logic                             third_prev_q;
	logic [csc_pkg::HoldW-1:0]        hold_q;
	logic [csc_pkg::CountW-1:0]       red_count_q;
	logic [csc_pkg::CountW-1:0]       yellow_count_q;
	logic [csc_pkg::CountW-1:0]       blue_count_q;

	logic                             busy;
	logic [csc_pkg::HoldW-1:0]        hold_dec;
	logic [csc_pkg::DelayW-1:0]       red_e1;
	logic [csc_pkg::DelayW-1:0]       yellow_e1;
	logic [csc_pkg::DelayW-1:0]       red_e2;
	logic [csc_pkg::DelayW-1:0]       yellow_e2;
	csc_pkg::color_t                  color1;
	csc_pkg::color_t                  color2;
	csc_pkg::color_t                  color3;
	csc_pkg::color_t                  color4;
	logic                             red_arm;
	logic                             yellow_arm;
	logic                             red_armed1;
	logic                             yellow_armed1;
	logic                             push_r;
	logic                             push_y;
	logic                             blue_hit;
	logic [SumW-1:0]                  hold_sum;
	logic [csc_pkg::HoldW-1:0]        hold_next;
	logic [csc_pkg::CountW-1:0]       red_count_n;
	logic [csc_pkg::CountW-1:0]       yellow_count_n;
	logic [csc_pkg::CountW-1:0]       blue_count_n;

	assign fire = tick_ready && result_room;

	always_comb begin
		busy     = (hold_q != '0);
		hold_dec = busy ? hold_q - 1'b1 : hold_q;

		red_e1 = red_elapsed_q;
		if (red_armed_q && red_elapsed_q != csc_pkg::ELAPSED_MAX) begin
			red_e1 = red_elapsed_q + 1'b1;
		end
		yellow_e1 = yellow_elapsed_q;
		if (yellow_armed_q && yellow_elapsed_q != csc_pkg::ELAPSED_MAX) begin
			yellow_e1 = yellow_elapsed_q + 1'b1;
		end

		color1 = color_q;
		if (!busy && tick.sample_color != csc_pkg::COLOR_NONE) begin
			color1 = tick.sample_color;
		end

		red_arm    = !busy && !tick.sensor_one && !red_armed_q
			&& color1 == csc_pkg::COLOR_RED;
		red_armed1 = red_armed_q || red_arm;
		red_e2     = red_arm ? '0 : red_e1;
		push_r     = red_armed1 && (red_e2 >= cfg.red_delay);
		color2     = push_r ? csc_pkg::COLOR_NONE : color1;

		yellow_arm    = !busy && !tick.sensor_two && !yellow_armed_q
			&& color2 == csc_pkg::COLOR_YELLOW;
		yellow_armed1 = yellow_armed_q || yellow_arm;
		yellow_e2     = yellow_arm ? '0 : yellow_e1;
		push_y        = yellow_armed1 && (yellow_e2 >= cfg.yellow_delay);
		color3        = push_y ? csc_pkg::COLOR_NONE : color2;

		blue_hit = !busy && third_prev_q && !tick.sensor_three
			&& color3 == csc_pkg::COLOR_BLUE;
		color4   = blue_hit ? csc_pkg::COLOR_NONE : color3;

		hold_sum = SumW'(hold_dec)
			+ (push_r ? SumW'(cfg.servo_hold) : '0)
			+ (push_y ? SumW'(cfg.servo_hold) : '0);
		hold_next = (hold_sum > SumW'(csc_pkg::HOLD_MAX)) ? csc_pkg::HOLD_MAX
			: hold_sum[csc_pkg::HoldW-1:0];

		red_count_n    = push_r ? red_count_q + 1'b1 : red_count_q;
		yellow_count_n = push_y ? yellow_count_q + 1'b1 : yellow_count_q;
		blue_count_n   = blue_hit ? blue_count_q + 1'b1 : blue_count_q;

		result.push_red     = push_r;
		result.push_yellow  = push_y;
		result.blue_passed  = blue_hit;
		result.held_color   = color4;
		result.red_total    = red_count_n;
		result.yellow_total = yellow_count_n;
		result.blue_total   = blue_count_n;
		result.busy         = busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q          <= csc_pkg::COLOR_NONE;
			red_armed_q      <= 1'b0;
			yellow_armed_q   <= 1'b0;
			red_elapsed_q    <= '0;
			yellow_elapsed_q <= '0;
			third_prev_q     <= 1'b1;
			hold_q           <= '0;
			red_count_q      <= '0;
			yellow_count_q   <= '0;
			blue_count_q     <= '0;
		end else if (fire) begin
			color_q          <= color4;
			red_armed_q      <= red_armed1 && !push_r;
			yellow_armed_q   <= yellow_armed1 && !push_y;
			red_elapsed_q    <= red_e2;
			yellow_elapsed_q <= yellow_e2;
			third_prev_q     <= busy ? third_prev_q : tick.sensor_three;
			hold_q           <= hold_next;
			red_count_q      <= red_count_n;
			yellow_count_q   <= yellow_count_n;
			blue_count_q     <= blue_count_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/color_sorter_controller_top.sv -----
// Top level of the color sorter controller: configuration registers, front, queues and back.
// Depends on csc_pkg, csc_fifo, csc_front and csc_back.
`timescale 1ns / 1ps
`default_nettype none

// One input transfer is one millisecond tick, and each tick yields exactly one result.
// The block takes one tick per clock while full is low and gives one result per clock
// when pop is held high. An accepted tick is classified combinationally and written into
// the middle queue. The back part updates its timers and counts from it when it leaves
// that queue while the output queue has room, and writes its result into the output
// queue, from which it can be popped. The per-tick state update in the back part sets
// the rate. The registers red_delay_ticks, yellow_delay_ticks and servo_hold_ticks lie at
// byte addresses 0, 4 and 8, and should be written only while both queues are empty.
module color_sorter_controller_top #(
	parameter int unsigned MID_DEPTH = csc_pkg::MID_DEPTH_DEFAULT,
	parameter int unsigned OUT_DEPTH = csc_pkg::OUT_DEPTH_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [csc_pkg::AddrW-1:0]  paddr,
	input  wire logic [csc_pkg::DataW-1:0]  pwdata,
	output logic [csc_pkg::DataW-1:0]       prdata,
	output logic                            pready,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic                       color_valid,
	input  wire logic [csc_pkg::WidthW-1:0] red_width,
	input  wire logic [csc_pkg::WidthW-1:0] green_width,
	input  wire logic [csc_pkg::WidthW-1:0] blue_width,
	input  wire logic                       sensor_one_level,
	input  wire logic                       sensor_two_level,
	input  wire logic                       sensor_three_level,
	input  wire logic                       pop,
	output logic                            empty,
	output logic                            push_red,
	output logic                            push_yellow,
	output logic                            blue_passed,
	output logic [1:0]                      held_color,
	output logic [csc_pkg::CountW-1:0]      red_total,
	output logic [csc_pkg::CountW-1:0]      yellow_total,
	output logic [csc_pkg::CountW-1:0]      blue_total,
	output logic                            busy_res
);

	csc_pkg::cfg_t    cfg_q;
	csc_pkg::tick_t   front_tick;
	csc_pkg::tick_t   back_tick;
	csc_pkg::result_t back_result;
	csc_pkg::result_t out_result;
	logic             mid_empty;
	logic             out_full;
	logic             back_fire;
	logic             cfg_wr;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_delay    <= csc_pkg::RED_DELAY_RESET;
			cfg_q.yellow_delay <= csc_pkg::YELLOW_DELAY_RESET;
			cfg_q.servo_hold   <= csc_pkg::SERVO_HOLD_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				csc_pkg::REG_RED_DELAY: begin
					cfg_q.red_delay <= pwdata[csc_pkg::DelayW-1:0];
				end
				csc_pkg::REG_YELLOW_DELAY: begin
					cfg_q.yellow_delay <= pwdata[csc_pkg::DelayW-1:0];
				end
				csc_pkg::REG_SERVO_HOLD: begin
					cfg_q.servo_hold <= pwdata[csc_pkg::HoldCfgW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			csc_pkg::REG_RED_DELAY:    prdata = csc_pkg::DataW'(cfg_q.red_delay);
			csc_pkg::REG_YELLOW_DELAY: prdata = csc_pkg::DataW'(cfg_q.yellow_delay);
			csc_pkg::REG_SERVO_HOLD:   prdata = csc_pkg::DataW'(cfg_q.servo_hold);
			default:                   prdata = '0;
		endcase
	end

	csc_front u_front (
		.color_valid        (color_valid),
		.red_width          (red_width),
		.green_width        (green_width),
		.blue_width         (blue_width),
		.sensor_one_level   (sensor_one_level),
		.sensor_two_level   (sensor_two_level),
		.sensor_three_level (sensor_three_level),
		.tick               (front_tick)
	);

	csc_fifo #(
		.WIDTH ($bits(csc_pkg::tick_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_tick),
		.full    (full),
		.rd_en   (back_fire),
		.rd_data (back_tick),
		.empty   (mid_empty)
	);

	csc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.tick        (back_tick),
		.tick_ready  (!mid_empty),
		.result_room (!out_full),
		.fire        (back_fire),
		.result      (back_result)
	);

	csc_fifo #(
		.WIDTH ($bits(csc_pkg::result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_fire),
		.wr_data (back_result),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_result),
		.empty   (empty)
	);

	assign push_red     = out_result.push_red;
	assign push_yellow  = out_result.push_yellow;
	assign blue_passed  = out_result.blue_passed;
	assign held_color   = out_result.held_color;
	assign red_total    = out_result.red_total;
	assign yellow_total = out_result.yellow_total;
	assign blue_total   = out_result.blue_total;
	assign busy_res     = out_result.busy;

endmodule

`default_nettype wire
